[design/iis_pkg.sv]
`timescale 1ns / 1ps
// Package for the integral image streamer: field widths, register indexes,
// reset values and the per-item control flags shared by front and back end.
// No dependencies.
package iis_pkg;

   // Field and register widths
   localparam int PIXEL_W      = 8;
   localparam int SUM_W        = 32;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   // Register reset values
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd768;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Classification of one item, made by the front end
   typedef struct packed {
      logic use_up;     // a row above exists
      logic use_up2;    // two rows above exist
      logic use_left;   // upper-left tilted neighbour applies
      logic use_right;  // upper-right tilted neighbour applies
      logic row_end;    // last pixel of a row
      logic frame_end;  // last pixel of the frame
   } item_flags_type;

endpackage

[design/iis_front.sv]
`timescale 1ns / 1ps
// Front end of the integral image streamer: raster position counters and
// per-item classification (neighbour use, row end, frame end, buffer addresses).
// Depends on iis_pkg.
module iis_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  logic [iis_pkg::WIDTH_REG_W-1:0]         image_width,
   input  logic [iis_pkg::HEIGHT_REG_W-1:0]        image_height,
   output logic [$clog2(MAX_WIDTH)-1:0]            col,
   output logic [$clog2(MAX_WIDTH)-1:0]            left_col,
   output logic [$clog2(MAX_WIDTH)-1:0]            right_col,
   output iis_pkg::item_flags_type                 flags
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int RW1 = iis_pkg::HEIGHT_REG_W + 1;

   logic [AW-1:0]                     col_ff, col_in;
   logic [iis_pkg::HEIGHT_REG_W-1:0]  row_ff, row_in;
   logic [WW-1:0]                     eff_width;
   logic [WW-1:0]                     col_inc;
   logic [iis_pkg::HEIGHT_REG_W-1:0]  eff_height;
   logic [RW1-1:0]                    row_inc;
   logic                              row_end;
   logic                              frame_end;

   // Effective frame size: zero acts as one, width is clamped to the buffers
   always_comb begin
      if (image_width == '0) begin
         eff_width = WW'(1);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(image_width);
      end
      eff_height = (image_height == '0) ? iis_pkg::HEIGHT_REG_W'(1) : image_height;
   end

   // Classification of the current position
   always_comb begin
      col_inc   = WW'(col_ff) + WW'(1);
      row_inc   = {1'b0, row_ff} + RW1'(1);
      row_end   = (col_inc >= eff_width);
      frame_end = row_end && (row_inc >= {1'b0, eff_height});

      flags.use_up    = (row_ff != '0);
      flags.use_up2   = (row_ff[iis_pkg::HEIGHT_REG_W-1:1] != '0);
      flags.use_left  = (row_ff != '0) && (col_ff != '0);
      flags.use_right = (row_ff != '0) && !row_end;
      flags.row_end   = row_end;
      flags.frame_end = frame_end;

      col = col_ff;
      left_col = (col_ff == '0) ? '0 : col_ff - AW'(1);
      if (32'(col_inc) < 32'(MAX_WIDTH)) begin
         right_col = col_inc[AW-1:0];
      end else begin
         right_col = col_ff;
      end
   end

   // Next position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_inc[iis_pkg::HEIGHT_REG_W-1:0];
         end else begin
            col_in = col_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Counters restart after the last pixel of a frame
   assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("position counters did not restart after frame end");

endmodule

[design/iis_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between the front and back end of the integral image
// streamer. Generic payload width; no package dependency.
module iis_queue #(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              pop,
   output logic [DATA_W-1:0] rd_data,
   output logic              full,
   output logic              empty
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[design/iis_back.sv]
`timescale 1ns / 1ps
// Back end of the integral image streamer: line buffers, running row sums,
// sum arithmetic with write forwarding, and the output register.
// Depends on iis_pkg.
module iis_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  logic [iis_pkg::PIXEL_W-1:0]         q_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]        q_col,
   input  logic [$clog2(MAX_WIDTH)-1:0]        q_left_col,
   input  logic [$clog2(MAX_WIDTH)-1:0]        q_right_col,
   input  iis_pkg::item_flags_type             q_flags,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [iis_pkg::SUM_W-1:0]           rsp_area_sum,
   output logic [iis_pkg::SUM_W-1:0]           rsp_square_sum,
   output logic [iis_pkg::SUM_W-1:0]           rsp_tilted_sum,
   output logic                                rsp_frame_end
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int SW = iis_pkg::SUM_W;
   localparam int PW = iis_pkg::PIXEL_W;

   // Line buffers
   logic [SW-1:0] area_mem_ff   [MAX_WIDTH];
   logic [SW-1:0] square_mem_ff [MAX_WIDTH];
   logic [PW-1:0] pixel_mem_ff  [MAX_WIDTH];
   logic [SW-1:0] tilt_mem_ff   [MAX_WIDTH];
   logic [SW-1:0] tilt2_mem_ff  [MAX_WIDTH];

   // Buffer read data
   logic [SW-1:0] rd_area_ff, rd_square_ff, rd_tilt_ff, rd_tilt_right_ff;
   logic [SW-1:0] rd_tilt2_ff, rd_tilt2_left_ff;
   logic [PW-1:0] rd_pixel_ff;

   // Compute stage
   logic                    s_valid_ff, s_valid_in;
   logic [PW-1:0]           s_pixel_ff;
   logic [AW-1:0]           s_col_ff, s_left_col_ff, s_right_col_ff;
   iis_pkg::item_flags_type s_flags_ff;

   // Last buffer write, forwarded to the item that read alongside it
   logic          wr_valid_ff, wr_valid_in;
   logic [AW-1:0] wr_addr_ff;
   logic [SW-1:0] wr_area_ff, wr_square_ff, wr_tilt_ff, wr_tilt2_ff;
   logic [PW-1:0] wr_pixel_ff;

   // Running row sums
   logic [SW-1:0] row_sum_ff, row_sum_in, row_sq_ff, row_sq_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_area_ff, rsp_square_ff, rsp_tilt_ff;
   logic          rsp_frame_end_ff;

   logic          adv;
   logic          mem_we;
   logic          hit_col, hit_left, hit_right;
   logic [SW-1:0] up_area, up_square, up_tilt, up_tilt2, left_tilt, right_tilt;
   logic [PW-1:0] up_pixel;
   logic [2*PW-1:0] pix_sq;
   logic [SW-1:0] row_sum_cur, row_sq_cur;
   logic [SW-1:0] area, square, tilt;

   // The back end moves as one whenever the output register can take an item
   assign adv    = !rsp_valid_ff || !rsp_stall;
   assign q_pop  = adv && q_valid;
   assign mem_we = adv && s_valid_ff;

   assign s_valid_in   = adv ? q_valid : s_valid_ff;
   assign wr_valid_in  = adv ? s_valid_ff : wr_valid_ff;
   assign rsp_valid_in = adv ? s_valid_ff : rsp_valid_ff;

   // Forwarding from the write that landed at the same edge as the read
   always_comb begin
      hit_col   = wr_valid_ff && (wr_addr_ff == s_col_ff);
      hit_left  = wr_valid_ff && (wr_addr_ff == s_left_col_ff);
      hit_right = wr_valid_ff && (wr_addr_ff == s_right_col_ff);

      up_area    = hit_col   ? wr_area_ff   : rd_area_ff;
      up_square  = hit_col   ? wr_square_ff : rd_square_ff;
      up_pixel   = hit_col   ? wr_pixel_ff  : rd_pixel_ff;
      up_tilt    = hit_col   ? wr_tilt_ff   : rd_tilt_ff;
      up_tilt2   = hit_col   ? wr_tilt2_ff  : rd_tilt2_ff;
      left_tilt  = hit_left  ? wr_tilt2_ff  : rd_tilt2_left_ff;
      right_tilt = hit_right ? wr_tilt_ff   : rd_tilt_right_ff;
   end

   // Sums for the item in the compute stage
   always_comb begin
      pix_sq      = s_pixel_ff * s_pixel_ff;
      row_sum_cur = row_sum_ff + SW'(s_pixel_ff);
      row_sq_cur  = row_sq_ff + SW'(pix_sq);

      area   = row_sum_cur + (s_flags_ff.use_up ? up_area   : '0);
      square = row_sq_cur  + (s_flags_ff.use_up ? up_square : '0);
      tilt   = SW'(s_pixel_ff)
             + (s_flags_ff.use_up    ? SW'(up_pixel) : '0)
             + (s_flags_ff.use_left  ? left_tilt     : '0)
             + (s_flags_ff.use_right ? right_tilt    : '0)
             - (s_flags_ff.use_up2   ? up_tilt2      : '0);

      row_sum_in = row_sum_ff;
      row_sq_in  = row_sq_ff;
      if (mem_we) begin
         row_sum_in = s_flags_ff.row_end ? '0 : row_sum_cur;
         row_sq_in  = s_flags_ff.row_end ? '0 : row_sq_cur;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_sum_ff   <= '0;
         row_sq_ff    <= '0;
      end else begin
         s_valid_ff   <= s_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_sum_ff   <= row_sum_in;
         row_sq_ff    <= row_sq_in;
      end
   end

   // Line buffers: read on pop, write as an item leaves the compute stage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_area_ff       <= area_mem_ff[q_col];
         rd_square_ff     <= square_mem_ff[q_col];
         rd_pixel_ff      <= pixel_mem_ff[q_col];
         rd_tilt_ff       <= tilt_mem_ff[q_col];
         rd_tilt_right_ff <= tilt_mem_ff[q_right_col];
         rd_tilt2_ff      <= tilt2_mem_ff[q_col];
         rd_tilt2_left_ff <= tilt2_mem_ff[q_left_col];
      end
      if (mem_we) begin
         area_mem_ff[s_col_ff]   <= area;
         square_mem_ff[s_col_ff] <= square;
         pixel_mem_ff[s_col_ff]  <= s_pixel_ff;
         tilt_mem_ff[s_col_ff]   <= tilt;
         tilt2_mem_ff[s_col_ff]  <= up_tilt;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s_pixel_ff     <= q_pixel;
         s_col_ff       <= q_col;
         s_left_col_ff  <= q_left_col;
         s_right_col_ff <= q_right_col;
         s_flags_ff     <= q_flags;
      end
      if (mem_we) begin
         wr_addr_ff       <= s_col_ff;
         wr_area_ff       <= area;
         wr_square_ff     <= square;
         wr_pixel_ff      <= s_pixel_ff;
         wr_tilt_ff       <= tilt;
         wr_tilt2_ff      <= up_tilt;
         rsp_area_ff      <= area;
         rsp_square_ff    <= square;
         rsp_tilt_ff      <= tilt;
         rsp_frame_end_ff <= s_flags_ff.frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_area_sum   = rsp_area_ff;
   assign rsp_square_sum = rsp_square_ff;
   assign rsp_tilted_sum = rsp_tilt_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

   // Upper-left neighbour never used in the first column
   assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && s_flags_ff.use_left |-> s_col_ff != '0)
      else $error("upper-left neighbour flagged in first column");

   // Frame end only on a row end, two rows above only with one row above
   assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> (!s_flags_ff.frame_end || s_flags_ff.row_end)
                     && (!s_flags_ff.use_up2 || s_flags_ff.use_up))
      else $error("inconsistent item classification");

   // Running sums restart after a row end leaves the compute stage
   assert property (@(posedge clock) disable iff (reset)
      mem_we && s_flags_ff.row_end |=> row_sum_ff == '0 && row_sq_ff == '0)
      else $error("running row sums not cleared at row end");

   // A buffer write is always recorded for forwarding
   assert property (@(posedge clock) disable iff (reset)
      mem_we |=> wr_valid_ff && wr_addr_ff == $past(s_col_ff))
      else $error("forwarding record lost a buffer write");

endmodule

[design/integral_image_streamer_unit.sv]
`timescale 1ns / 1ps
// Integral image streamer, top level: configuration registers and the
// front end, queue and back end. Depends on iis_pkg, iis_front, iis_queue, iis_back.
//
// Usage: 8-bit gray pixels enter in raster order on the req_ channel
// (req_valid / req_stall / req_pixel). For every pixel one item leaves on
// the rsp_ channel: summed-area value, summed-area value of squares, the
// 45-degree tilted sum (all modulo 2^32) and a frame_end flag on the last
// pixel of the frame. Frame width (index 0) and height (index 1) are set
// through csr_write / csr_index / csr_wdata while no item is in flight.
// An accepted pixel passes the queue, compute stage and output register
// before rsp_valid. One pixel is taken per cycle sustained while rsp_stall
// is low; the limit is the single write port of each line buffer, written
// once per pixel. A two-entry queue between the position counters and the
// arithmetic lets up to two more pixels be taken while a result waits under
// rsp_stall; after that req_stall rises. Reset clears the position counters,
// running row sums and all valids and loads width 1024, height 768. The line
// buffers are not cleared: entries are always written one row before they are read.
module integral_image_streamer_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [iis_pkg::PIXEL_W-1:0]          req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [iis_pkg::SUM_W-1:0]            rsp_area_sum,
   output logic [iis_pkg::SUM_W-1:0]            rsp_square_sum,
   output logic [iis_pkg::SUM_W-1:0]            rsp_tilted_sum,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write,
   input  logic [iis_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [iis_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int FW = $bits(iis_pkg::item_flags_type);
   localparam int QW = iis_pkg::PIXEL_W + 3 * AW + FW;

   logic [iis_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [iis_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;

   logic                    accept;
   logic [AW-1:0]           f_col, f_left_col, f_right_col;
   iis_pkg::item_flags_type f_flags;

   logic [QW-1:0]           q_wr_data, q_rd_data;
   logic                    q_full, q_empty, q_pop;
   logic [iis_pkg::PIXEL_W-1:0] q_pixel;
   logic [AW-1:0]           q_col, q_left_col, q_right_col;
   iis_pkg::item_flags_type q_flags;

   // Configuration register decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (iis_pkg::csr_index_type'(csr_index))
            iis_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wdata[iis_pkg::WIDTH_REG_W-1:0];
            iis_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata[iis_pkg::HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= iis_pkg::WIDTH_RESET;
         height_ff <= iis_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Input handshake: take a pixel whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   iis_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .col          (f_col),
      .left_col     (f_left_col),
      .right_col    (f_right_col),
      .flags        (f_flags)
   );

   // Queue entry layout
   assign q_wr_data = {req_pixel, f_col, f_left_col, f_right_col, f_flags};
   assign {q_pixel, q_col, q_left_col, q_right_col, q_flags} = q_rd_data;

   iis_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   iis_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (!q_empty),
      .q_pop          (q_pop),
      .q_pixel        (q_pixel),
      .q_col          (q_col),
      .q_left_col     (q_left_col),
      .q_right_col    (q_right_col),
      .q_flags        (q_flags),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_area_sum   (rsp_area_sum),
      .rsp_square_sum (rsp_square_sum),
      .rsp_tilted_sum (rsp_tilted_sum),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for integral_image_streamer_unit: a line-buffer
// predictor of the area, square and tilted sums checks every result item.
// Depends on iis_pkg and the design files of the streamer.
module testbench;

   localparam int MAX_WIDTH        = 1024;
   localparam int RANDOM_ITEMS     = 250;
   localparam int SECOND_ROW_ITEMS = 8;
   localparam int DRAIN_CYCLES     = 4;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int PART_CAP         = 150;

   typedef struct packed {
      logic [iis_pkg::SUM_W-1:0] area;
      logic [iis_pkg::SUM_W-1:0] square;
      logic [iis_pkg::SUM_W-1:0] tilt;
      logic                      frame_end;
   } pixel_sums_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // Clock and block inputs, all known from time zero
   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic [iis_pkg::PIXEL_W-1:0]      req_pixel   = '0;
   logic                             rsp_stall   = 1'b0;
   logic                             csr_write   = 1'b0;
   logic [iis_pkg::CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [iis_pkg::CSR_DATA_W-1:0]   csr_wdata   = '0;
   logic                             req_stall;
   logic                             rsp_valid;
   logic [iis_pkg::SUM_W-1:0]        rsp_area_sum;
   logic [iis_pkg::SUM_W-1:0]        rsp_square_sum;
   logic [iis_pkg::SUM_W-1:0]        rsp_tilted_sum;
   logic                             rsp_frame_end;

   // Predictor state: registers, line buffers, running row sums, position
   logic [iis_pkg::WIDTH_REG_W-1:0]  width_setting  = iis_pkg::WIDTH_RESET;
   logic [iis_pkg::HEIGHT_REG_W-1:0] height_setting = iis_pkg::HEIGHT_RESET;
   logic [iis_pkg::SUM_W-1:0]        sums_above    [MAX_WIDTH];
   logic [iis_pkg::SUM_W-1:0]        squares_above [MAX_WIDTH];
   logic [iis_pkg::SUM_W-1:0]        tilts_above   [MAX_WIDTH];
   logic [iis_pkg::SUM_W-1:0]        tilts_above2  [MAX_WIDTH];
   logic [iis_pkg::PIXEL_W-1:0]      pixels_above  [MAX_WIDTH];
   logic [iis_pkg::SUM_W-1:0]        row_sum    = '0;
   logic [iis_pkg::SUM_W-1:0]        row_square = '0;
   int unsigned                      col_pos = 0;
   int unsigned                      row_pos = 0;

   pixel_sums_type expected_sums[$];

   int unsigned cycle_count    = 0;
   int unsigned error_count    = 0;
   int unsigned pixels_sent    = 0;
   int unsigned results_seen   = 0;
   int unsigned frames_seen    = 0;
   int unsigned csr_writes     = 0;
   int unsigned burst_left     = 0;
   int unsigned stall_left     = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   integral_image_streamer_unit #(
      .MAX_WIDTH(MAX_WIDTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_area_sum   (rsp_area_sum),
      .rsp_square_sum (rsp_square_sum),
      .rsp_tilted_sum (rsp_tilted_sum),
      .rsp_frame_end  (rsp_frame_end),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, expected_sums.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver stall pattern: modes of random length, none, light, heavy, periodic
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_left % 3 == 0);
      endcase
   end

   // Effective frame size, out-of-range settings clamped
   function automatic int unsigned frame_width();
      int unsigned w;
      w = 32'(width_setting);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned frame_height();
      return (height_setting == 0) ? 1 : 32'(height_setting);
   endfunction

   // Pixels left until the current frame ends, given the present settings
   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, cols_left, rows_after;
      w = frame_width();
      h = frame_height();
      cols_left = (col_pos + 1 >= w) ? 1 : w - col_pos;
      rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
      return cols_left + rows_after * w;
   endfunction

   // Expected sums of one accepted pixel; updates the line buffers and position
   task automatic predict_sums(input logic [iis_pkg::PIXEL_W-1:0] value);
      int unsigned w, h, i, j;
      logic [iis_pkg::SUM_W-1:0] pv, sq;
      logic row_end;
      pixel_sums_type r;
      w = frame_width();
      h = frame_height();
      i = row_pos;
      j = col_pos;
      if (j >= MAX_WIDTH) j = MAX_WIDTH - 1;
      pv = {{(iis_pkg::SUM_W-iis_pkg::PIXEL_W){1'b0}}, value};
      sq = pv * pv;
      row_sum = row_sum + pv;
      row_square = row_square + sq;
      r.area = row_sum;
      r.square = row_square;
      r.tilt = pv;
      if (i > 0) begin
         r.area = r.area + sums_above[j];
         r.square = r.square + squares_above[j];
         r.tilt = r.tilt + {{(iis_pkg::SUM_W-iis_pkg::PIXEL_W){1'b0}}, pixels_above[j]};
         // upper-left tilted value has already moved to the two-rows buffer
         if (j > 0) r.tilt = r.tilt + tilts_above2[j-1];
         if (j + 1 < w && j + 1 < MAX_WIDTH) r.tilt = r.tilt + tilts_above[j+1];
      end
      if (i > 1) r.tilt = r.tilt - tilts_above2[j];
      sums_above[j] = r.area;
      squares_above[j] = r.square;
      tilts_above2[j] = tilts_above[j];
      tilts_above[j] = r.tilt;
      pixels_above[j] = value;
      row_end = (j + 1 >= w);
      r.frame_end = row_end && (i + 1 >= h);
      if (row_end) begin
         col_pos = 0;
         row_sum = '0;
         row_square = '0;
         row_pos = r.frame_end ? 0 : ((i + 1) & 16'hFFFF);
      end else begin
         col_pos = j + 1;
      end
      expected_sums.push_back(r);
   endtask

   // Send one item; bursts of random length separated by random gaps
   task automatic send_pixel(input logic [iis_pkg::PIXEL_W-1:0] value);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      do @(posedge clock); while (req_stall);
      burst_left--;
      pixels_sent++;
      predict_sums(value);
   endtask

   function automatic logic [iis_pkg::PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return iis_pkg::PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_pixels(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // Lower valid, wait for every expected result and let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_register(input iis_pkg::csr_index_type index,
                                 input logic [iis_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == iis_pkg::REG_IMAGE_WIDTH) width_setting = data[iis_pkg::WIDTH_REG_W-1:0];
      else height_setting = data;
      csr_writes++;
   endtask

   // Result checker: each accepted item against the oldest expectation
   always @(posedge clock) begin : check_results
      pixel_sums_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_frame_end === 1'b1) frames_seen++;
         if (expected_sums.size() == 0) begin
            $display("%0t: result with nothing expected: area %0d square %0d tilt %0d",
                     $time, rsp_area_sum, rsp_square_sum, rsp_tilted_sum);
            error_count++;
         end else begin
            want = expected_sums.pop_front();
            if (rsp_area_sum !== want.area) begin
               $display("%0t: area_sum expected %0d, got %0d",
                        $time, want.area, rsp_area_sum);
               error_count++;
            end
            if (rsp_square_sum !== want.square) begin
               $display("%0t: square_sum expected %0d, got %0d",
                        $time, want.square, rsp_square_sum);
               error_count++;
            end
            if (rsp_tilted_sum !== want.tilt) begin
               $display("%0t: tilted_sum expected %0d, got %0d",
                        $time, want.tilt, rsp_tilted_sum);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %0b, got %0b",
                        $time, want.frame_end, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   // Full-width first row at reset width; second row after an over-range width
   // write, cut short by shrinking the width so that the frame ends early
   task automatic test_full_width();
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd2);
      send_random_pixels(MAX_WIDTH);
      wait_idle();
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd2047);
      send_random_pixels(SECOND_ROW_ITEMS);
      wait_idle();
      write_register(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::CSR_DATA_W'(SECOND_ROW_ITEMS + 1));
      send_random_pixels(pixels_to_frame_end());
      wait_idle();
   endtask

   // 3x3 frame of full-scale and zero pixels
   task automatic test_pixel_extremes();
      logic [iis_pkg::PIXEL_W-1:0] pattern [9];
      pattern = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd3);
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd3);
      foreach (pattern[k]) send_pixel(pattern[k]);
      wait_idle();
   endtask

   // Zero width and height act as one; single-column frame
   task automatic test_degenerate_sizes();
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd0);
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd0);
      send_random_pixels(2);
      wait_idle();
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd1);
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd3);
      send_random_pixels(3);
      wait_idle();
   endtask

   // Width shrunk below the column and height cut below the row mid-frame
   task automatic test_mid_frame_change();
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd4);
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
      send_random_pixels(6);
      wait_idle();
      write_register(iis_pkg::REG_IMAGE_WIDTH, 16'd2);
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd2);
      send_random_pixels(4);
      wait_idle();
      write_register(iis_pkg::REG_IMAGE_HEIGHT, 16'd1);
      send_random_pixels(pixels_to_frame_end());
      wait_idle();
   endtask

   // Random settings; mostly whole frames, some cut short and resized mid-frame.
   // Inside a frame the width only shrinks, so every line-buffer read finds an
   // entry written one row earlier.
   task automatic test_random_frames();
      int unsigned sent, count, w_val, h_val, w_eff;
      logic        frame_start;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w_val = $urandom_range(0, 1);
            1:       w_val = $urandom_range(13, 64);
            default: w_val = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       h_val = 0;
            1:       h_val = $urandom_range(6, 65535);
            default: h_val = $urandom_range(1, 5);
         endcase
         w_eff = (w_val == 0) ? 1 : w_val;
         frame_start = (col_pos == 0) && (row_pos == 0);
         if ($urandom_range(0, 4) != 0 && (frame_start || w_eff <= frame_width()))
            write_register(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::CSR_DATA_W'(w_val));
         if ($urandom_range(0, 4) != 0)
            write_register(iis_pkg::REG_IMAGE_HEIGHT, iis_pkg::CSR_DATA_W'(h_val));
         count = pixels_to_frame_end();
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         if (count > PART_CAP) count = PART_CAP;
         send_random_pixels(count);
         sent += count;
         wait_idle();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_full_width();
      test_pixel_extremes();
      test_degenerate_sizes();
      test_mid_frame_change();
      test_random_frames();
      wait_idle();

      $display("Run summary: %0d pixels sent, %0d results checked, %0d frames ended",
               pixels_sent, results_seen, frames_seen);
      $display("Settings: %0d register writes, widths 0 to 2047, heights 0 to 65535",
               csr_writes);
      if (error_count == 0 && expected_sums.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  expected_sums.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
